[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/msd_pkg.sv]
// Types and constants for the media stream deframer.
// Used by the parser, output register, top level and checker.
package msd_pkg;

	localparam int unsigned NAME_BYTES = 64;
	localparam logic [7:0] NAME_LIMIT = 8'(NAME_BYTES);

	localparam logic [6:0] HDR_BYTES   = 7'd12;
	localparam logic [6:0] STAMP_BYTES = 7'd8;
	localparam logic [6:0] VMETA_BYTES = 7'd12;
	localparam logic [6:0] AMETA_BYTES = 7'd4;
	localparam logic [6:0] CODEC_END   = 7'd4;
	localparam logic [6:0] WIDTH_END   = 7'd8;

	typedef enum logic [1:0] {
		PH_NAME = 2'd0,
		PH_META = 2'd1,
		PH_HEAD = 2'd2,
		PH_LOAD = 2'd3
	} msd_phase_t;

	typedef enum logic [1:0] {
		KIND_NAME    = 2'd0,
		KIND_VMETA   = 2'd1,
		KIND_AMETA   = 2'd2,
		KIND_PAYLOAD = 2'd3
	} msd_kind_t;

	localparam logic STREAM_VIDEO = 1'b0;
	localparam logic STREAM_AUDIO = 1'b1;

	typedef struct packed {
		msd_kind_t   kind;
		logic [7:0]  out_byte;
		logic [31:0] codec_id;
		logic [31:0] frame_width;
		logic [31:0] frame_height;
		logic        config_flag;
		logic        key_flag;
		logic [61:0] timestamp;
		logic [31:0] frame_length;
		logic        last;
	} msd_result_t;

endpackage

[hw/rtl/msd_parser.sv]
// Input register and stream parser: holds the parse state and forms at most
// one result per registered byte. Depends on msd_pkg.
module msd_parser import msd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        advance,
	output logic        src_valid,
	output logic        res_valid,
	output msd_result_t res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        restart_s1;

	logic        stream_kind_q;
	msd_phase_t  phase_q;
	logic [6:0]  count_q;
	logic [63:0] stamp_q;
	logic [31:0] word_q;
	logic [31:0] codec_q;
	logic [31:0] width_q;
	logic [31:0] length_q;
	logic [31:0] left_q;

	msd_phase_t  cur_phase, nxt_phase;
	logic [6:0]  cur_count, nxt_count, count_inc;
	logic [63:0] cur_stamp, nxt_stamp;
	logic [31:0] cur_word, nxt_word;
	logic [31:0] cur_codec, nxt_codec;
	logic [31:0] cur_width, nxt_width;
	logic [31:0] cur_length, nxt_length;
	logic [31:0] cur_left, nxt_left;
	logic        name_fin;
	logic        load_fin;
	logic        consume;

	assign in_ready  = !valid_s1 || advance;
	assign consume   = valid_s1 && advance;
	assign src_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	always_comb begin
		if (restart_s1) begin
			cur_phase  = stream_kind_q ? PH_META : PH_NAME;
			cur_count  = '0;
			cur_stamp  = '0;
			cur_word   = '0;
			cur_codec  = '0;
			cur_width  = '0;
			cur_length = '0;
			cur_left   = '0;
		end else begin
			cur_phase  = phase_q;
			cur_count  = count_q;
			cur_stamp  = stamp_q;
			cur_word   = word_q;
			cur_codec  = codec_q;
			cur_width  = width_q;
			cur_length = length_q;
			cur_left   = left_q;
		end
	end

	assign count_inc = cur_count + 7'd1;
	assign name_fin  = ({1'b0, cur_count} + 8'd1) >= NAME_LIMIT;
	assign load_fin  = cur_left <= 32'd1;

	always_comb begin
		nxt_phase  = cur_phase;
		nxt_count  = cur_count;
		nxt_stamp  = cur_stamp;
		nxt_word   = cur_word;
		nxt_codec  = cur_codec;
		nxt_width  = cur_width;
		nxt_length = cur_length;
		nxt_left   = cur_left;
		res_valid  = 1'b0;
		res        = '0;
		case (cur_phase)
			PH_NAME: begin
				res_valid    = 1'b1;
				res.kind     = KIND_NAME;
				res.out_byte = byte_s1;
				res.last     = name_fin;
				if (name_fin) begin
					nxt_phase = PH_META;
					nxt_count = '0;
				end else begin
					nxt_count = count_inc;
				end
			end
			PH_META: begin
				nxt_word  = {cur_word[23:0], byte_s1};
				nxt_count = count_inc;
				if (stream_kind_q == STREAM_VIDEO && count_inc == CODEC_END) begin
					nxt_codec = nxt_word;
				end
				if (stream_kind_q == STREAM_VIDEO && count_inc == WIDTH_END) begin
					nxt_width = nxt_word;
				end
				if (count_inc >= (stream_kind_q ? AMETA_BYTES : VMETA_BYTES)) begin
					nxt_count = '0;
					nxt_phase = PH_HEAD;
					res_valid = 1'b1;
					if (stream_kind_q == STREAM_AUDIO) begin
						res.kind     = KIND_AMETA;
						res.codec_id = nxt_word;
					end else begin
						res.kind         = KIND_VMETA;
						res.codec_id     = cur_codec;
						res.frame_width  = cur_width;
						res.frame_height = nxt_word;
					end
				end
			end
			PH_HEAD: begin
				if (cur_count < STAMP_BYTES) begin
					nxt_stamp = {cur_stamp[55:0], byte_s1};
				end else begin
					nxt_word = {cur_word[23:0], byte_s1};
				end
				nxt_count = count_inc;
				if (count_inc >= HDR_BYTES) begin
					nxt_count = '0;
					if (nxt_word != 32'd0) begin
						nxt_length = nxt_word;
						nxt_left   = nxt_word;
						nxt_phase  = PH_LOAD;
					end
				end
			end
			PH_LOAD: begin
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.out_byte     = byte_s1;
				res.config_flag  = cur_stamp[63];
				res.key_flag     = cur_stamp[62];
				res.timestamp    = cur_stamp[61:0];
				res.frame_length = cur_length;
				res.last         = load_fin;
				if (load_fin) begin
					nxt_left  = '0;
					nxt_phase = PH_HEAD;
					nxt_count = '0;
				end else begin
					nxt_left = cur_left - 32'd1;
				end
			end
			default: begin
				nxt_phase = cur_phase;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_kind_q <= STREAM_VIDEO;
			phase_q       <= PH_NAME;
			count_q       <= '0;
			stamp_q       <= '0;
			word_q        <= '0;
			codec_q       <= '0;
			width_q       <= '0;
			length_q      <= '0;
			left_q        <= '0;
		end else if (cfg_wr_en) begin
			stream_kind_q <= cfg_wr_data;
			phase_q       <= cfg_wr_data ? PH_META : PH_NAME;
			count_q       <= '0;
			stamp_q       <= '0;
			word_q        <= '0;
			codec_q       <= '0;
			width_q       <= '0;
			length_q      <= '0;
			left_q        <= '0;
		end else if (consume) begin
			phase_q  <= nxt_phase;
			count_q  <= nxt_count;
			stamp_q  <= nxt_stamp;
			word_q   <= nxt_word;
			codec_q  <= nxt_codec;
			width_q  <= nxt_width;
			length_q <= nxt_length;
			left_q   <= nxt_left;
		end
	end

endmodule

[hw/rtl/msd_out_reg.sv]
// Result register with valid and ready toward the receiver.
// Depends on msd_pkg for the result struct.
module msd_out_reg import msd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	input  logic        src_has_result,
	input  msd_result_t src_res,
	output logic        advance,
	output logic        out_valid,
	input  logic        out_ready,
	output msd_result_t res_q
);

	logic valid_q;

	assign advance   = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= src_valid && src_has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && src_valid && src_has_result) begin
			res_q <= src_res;
		end
	end

endmodule

[hw/rtl/media_stream_deframer_unit.sv]
// Media stream deframer, top level.
// Depends on msd_pkg, msd_parser and msd_out_reg.
//
// Input channel: one stream byte per item (data_byte, restart) on
// in_valid / in_ready. restart set on an item starts parsing over at the
// stream start, with that byte as the first byte of the stream.
// Output channel: at most one result per input item on out_valid /
// out_ready: a name byte, a video or audio metadata record, or a payload
// byte tagged with its frame's flags, timestamp and length.
// Configuration: cfg_wr_en writes cfg_wr_data into stream_kind (0 video,
// 1 audio) and restarts parsing; write only while the block is idle.
// Path: an accepted item is held in the input register, and the parse step
// runs from the input register into the result register that drives the outputs.
// Throughput: one item per cycle while the receiver does not stall; the whole
// parse step sits between the input register and the result register.
// Reset: clears both valid flags and returns parsing to the video name
// phase. When the receiver stalls, the result register holds and the input
// register fills, then in_ready drops until out_ready returns.
module media_stream_deframer_unit import msd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [31:0] codec_id,
	output logic [31:0] frame_width,
	output logic [31:0] frame_height,
	output logic        config_flag,
	output logic        key_flag,
	output logic [61:0] timestamp,
	output logic [31:0] frame_length,
	output logic        last
);

	logic        advance;
	logic        src_valid;
	logic        res_valid;
	msd_result_t res;
	msd_result_t res_q;

	msd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.restart     (restart),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.src_valid   (src_valid),
		.res_valid   (res_valid),
		.res         (res)
	);

	msd_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.src_valid      (src_valid),
		.src_has_result (res_valid),
		.src_res        (res),
		.advance        (advance),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.res_q          (res_q)
	);

	assign kind         = res_q.kind;
	assign out_byte     = res_q.out_byte;
	assign codec_id     = res_q.codec_id;
	assign frame_width  = res_q.frame_width;
	assign frame_height = res_q.frame_height;
	assign config_flag  = res_q.config_flag;
	assign key_flag     = res_q.key_flag;
	assign timestamp    = res_q.timestamp;
	assign frame_length = res_q.frame_length;
	assign last         = res_q.last;

endmodule

[hw/rtl/msd_checker.sv]
// Port-level checker for the media stream deframer, bound to the top level.
// Depends on msd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module msd_checker import msd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  out_byte,
	input logic [31:0] codec_id,
	input logic [31:0] frame_width,
	input logic [31:0] frame_height,
	input logic        config_flag,
	input logic        key_flag,
	input logic [61:0] timestamp,
	input logic [31:0] frame_length,
	input logic        last
);

	logic [202:0] out_bits;

	assign out_bits = {kind, out_byte, codec_id, frame_width, frame_height,
		config_flag, key_flag, timestamp, frame_length, last};

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_bits))
	`ASSERT_NOW(a_load_len, clk, arst_n, out_valid && kind == KIND_PAYLOAD, frame_length != 32'd0)
	`ASSERT_NOW(a_meta_clean, clk, arst_n, out_valid && (kind == KIND_VMETA || kind == KIND_AMETA), out_byte == 8'd0 && !last && timestamp == 62'd0)
	`ASSERT_NOW(a_stall_full, clk, arst_n, out_valid && !out_ready && !in_ready, !in_valid || !in_ready)

endmodule

bind media_stream_deframer_unit msd_checker u_msd_checker (.*);
